// ===== rtl/rcw_pkg.sv =====
// Package with the word types, command codes and constants of the Reno congestion window block.
`default_nettype none
package rcw_pkg;

  localparam int unsigned FIELD_WIN_W = 11;
  localparam int unsigned COUNT_W     = 16;

  typedef logic [FIELD_WIN_W-1:0] win_field_t;
  typedef logic [COUNT_W-1:0]     unit_count_t;

  localparam logic [1:0] OP_ACK      = 2'd0;
  localparam logic [1:0] OP_TIMEOUT  = 2'd1;
  localparam logic [1:0] OP_LOAD     = 2'd2;
  localparam logic [1:0] OP_RESTART  = 2'd3;

  localparam logic [1:0] EK_NEW      = 2'd0;
  localparam logic [1:0] EK_DUP      = 2'd1;
  localparam logic [1:0] EK_TIMEOUT  = 2'd2;
  localparam logic [1:0] EK_CONTROL  = 2'd3;

  localparam logic [1:0] PH_SS       = 2'd0;
  localparam logic [1:0] PH_CA       = 2'd1;
  localparam logic [1:0] PH_FR       = 2'd2;

  localparam logic [1:0] CFG_CC_ENABLE      = 2'd0;
  localparam logic [1:0] CFG_INIT_WINDOW    = 2'd1;
  localparam logic [1:0] CFG_INIT_THRESHOLD = 2'd2;

  localparam logic [1:0]  DUP_TRIGGER      = 2'd3;
  localparam int unsigned RESET_THRESHOLD  = 16;
  localparam logic [31:0] EXPECTED_RESET   = 32'd38;
  localparam win_field_t  INIT_WINDOW_RESET = 11'd1;

  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] ack_number;
    logic [31:0] expected_base;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  event_kind;
    win_field_t  acked_count;
    win_field_t  window_now;
    win_field_t  threshold_now;
    logic [1:0]  phase_now;
    logic        fast_retransmit;
    logic [15:0] timeouts_total;
    logic [15:0] fast_recoveries_total;
  } out_word_t;

  typedef enum logic [2:0] {
    CMD_NEW     = 3'd0,
    CMD_DUP     = 3'd1,
    CMD_TIMEOUT = 3'd2,
    CMD_LOAD    = 3'd3,
    CMD_RESTART = 3'd4
  } cmd_code_t;

  typedef struct packed {
    cmd_code_t   cmd;
    unit_count_t count;
  } cmd_word_t;

endpackage
`default_nettype wire

// ===== rtl/rcw_front.sv =====
// Front end: accepts input words, classifies acknowledgements and tracks the expected ack.
`default_nettype none
module rcw_front #(
  parameter int unsigned MAX_WINDOW = 1024
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire rcw_pkg::in_word_t in_data,
  output logic                   push_valid,
  input  wire logic              push_ready,
  output rcw_pkg::cmd_word_t     push_data
);

  logic [31:0] expected_ack_r;
  logic [31:0] expected_ack_nxt;
  logic [31:0] units;
  logic        ack_ahead;
  logic        take;

  assign in_ready   = push_ready;
  assign push_valid = in_valid;
  assign take       = in_valid && push_ready;

  assign ack_ahead = in_data.ack_number >= expected_ack_r;
  assign units     = in_data.ack_number - expected_ack_r + 32'd1;

  always_comb begin
    expected_ack_nxt = expected_ack_r;
    push_data.cmd    = rcw_pkg::CMD_LOAD;
    push_data.count  = '0;
    case (in_data.op)
      rcw_pkg::OP_ACK: begin
        if (ack_ahead) begin
          push_data.cmd = rcw_pkg::CMD_NEW;
          if (units > 32'(MAX_WINDOW)) begin
            push_data.count = rcw_pkg::unit_count_t'(MAX_WINDOW);
          end else begin
            push_data.count = rcw_pkg::unit_count_t'(units);
          end
          expected_ack_nxt = in_data.ack_number + 32'd1;
        end else begin
          push_data.cmd = rcw_pkg::CMD_DUP;
        end
      end
      rcw_pkg::OP_TIMEOUT: begin
        push_data.cmd = rcw_pkg::CMD_TIMEOUT;
      end
      rcw_pkg::OP_LOAD: begin
        push_data.cmd    = rcw_pkg::CMD_LOAD;
        expected_ack_nxt = in_data.expected_base;
      end
      default: begin
        push_data.cmd = rcw_pkg::CMD_RESTART;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      expected_ack_r <= rcw_pkg::EXPECTED_RESET;
    end else if (take) begin
      expected_ack_r <= expected_ack_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/rcw_queue.sv =====
// Two-entry command queue between the front end and the window engine.
`default_nettype none
module rcw_queue (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               push_valid,
  output logic                    push_ready,
  input  wire rcw_pkg::cmd_word_t push_data,
  output logic                    pop_valid,
  input  wire logic               pop_ready,
  output rcw_pkg::cmd_word_t      pop_data
);

  rcw_pkg::cmd_word_t slot_r [2];
  logic               wr_ptr_r;
  logic               rd_ptr_r;
  logic [1:0]         fill_r;
  logic               do_push;
  logic               do_pop;

  assign push_ready = fill_r != 2'd2;
  assign pop_valid  = fill_r != 2'd0;
  assign pop_data   = slot_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      fill_r   <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (do_pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      if (do_push && !do_pop) begin
        fill_r <= fill_r + 2'd1;
      end else if (do_pop && !do_push) begin
        fill_r <= fill_r - 2'd1;
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/rcw_back.sv =====
// Window engine: applies each command to the Reno state one acked unit per cycle.
`default_nettype none
module rcw_back #(
  parameter int unsigned MAX_WINDOW = 1024
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cc_enable,
  input  wire rcw_pkg::win_field_t  init_window,
  input  wire logic                 pop_valid,
  output logic                      pop_ready,
  input  wire rcw_pkg::cmd_word_t   pop_data,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output rcw_pkg::out_word_t        out_data
);

  localparam int unsigned WW = $clog2(MAX_WINDOW + 1);
  localparam logic [WW-1:0] WMAX = WW'(MAX_WINDOW);
  localparam logic [WW-1:0] SSL_RESET =
    (MAX_WINDOW < rcw_pkg::RESET_THRESHOLD) ? WW'(MAX_WINDOW) : WW'(rcw_pkg::RESET_THRESHOLD);

  typedef enum logic [2:0] {
    BK_IDLE = 3'b001,
    BK_EXEC = 3'b010,
    BK_EMIT = 3'b100
  } bk_state_t;

  bk_state_t            state_r, state_nxt;
  rcw_pkg::cmd_code_t   cmd_r;
  rcw_pkg::win_field_t  acked_r;
  logic [WW-1:0]        remain_r, remain_nxt;
  logic [1:0]           phase_r, phase_nxt;
  logic [WW-1:0]        cwnd_r, cwnd_nxt;
  logic [WW-1:0]        ssl_r, ssl_nxt;
  logic [1:0]           dup_r, dup_nxt;
  logic [WW-1:0]        avoid_r, avoid_nxt;
  logic [15:0]          tmo_tally_r, tmo_tally_nxt;
  logic [15:0]          rec_tally_r, rec_tally_nxt;
  logic                 fr_r, fr_nxt;
  logic                 out_valid_r;
  rcw_pkg::out_word_t   out_data_r;
  logic                 load_out;
  logic [1:0]           kind;

  function automatic logic [WW-1:0] sat_inc(input logic [WW-1:0] v);
    return (v >= WMAX) ? WMAX : v + WW'(1);
  endfunction

  function automatic logic [WW-1:0] halved(input logic [WW-1:0] v);
    return ((v >> 1) == '0) ? WW'(1) : (v >> 1);
  endfunction

  function automatic logic [WW-1:0] clamp_init(input rcw_pkg::win_field_t v);
    logic [31:0] wide;
    wide = 32'(v);
    if (wide == 32'd0) begin
      return WW'(1);
    end else if (wide > 32'(MAX_WINDOW)) begin
      return WMAX;
    end
    return WW'(wide);
  endfunction

  function automatic logic [WW-1:0] recovery_window(input logic [WW-1:0] v);
    logic [WW:0] sum;
    sum = {1'b0, v} + (WW+1)'(rcw_pkg::DUP_TRIGGER);
    return (sum > {1'b0, WMAX}) ? WMAX : WW'(sum);
  endfunction

  assign pop_ready = state_r == BK_IDLE;
  assign load_out  = (state_r == BK_EMIT) && (!out_valid_r || out_ready);

  always_comb begin
    state_nxt     = state_r;
    remain_nxt    = remain_r;
    phase_nxt     = phase_r;
    cwnd_nxt      = cwnd_r;
    ssl_nxt       = ssl_r;
    dup_nxt       = dup_r;
    avoid_nxt     = avoid_r;
    tmo_tally_nxt = tmo_tally_r;
    rec_tally_nxt = rec_tally_r;
    fr_nxt        = fr_r;
    case (state_r)
      BK_IDLE: begin
        fr_nxt     = 1'b0;
        remain_nxt = WW'(pop_data.count);
        if (pop_valid) begin
          state_nxt = BK_EXEC;
        end
      end
      BK_EXEC: begin
        state_nxt = BK_EMIT;
        case (cmd_r)
          rcw_pkg::CMD_NEW: begin
            if (cc_enable && remain_r != '0) begin
              state_nxt  = BK_EXEC;
              remain_nxt = remain_r - WW'(1);
              dup_nxt    = 2'd0;
              if (phase_r == rcw_pkg::PH_SS) begin
                cwnd_nxt = sat_inc(cwnd_r);
                if (sat_inc(cwnd_r) > ssl_r) begin
                  phase_nxt = rcw_pkg::PH_CA;
                  avoid_nxt = '0;
                end
              end else if (phase_r == rcw_pkg::PH_CA) begin
                if (sat_inc(avoid_r) >= cwnd_r) begin
                  avoid_nxt = '0;
                  cwnd_nxt  = sat_inc(cwnd_r);
                end else begin
                  avoid_nxt = sat_inc(avoid_r);
                end
              end else begin
                phase_nxt = rcw_pkg::PH_CA;
                cwnd_nxt  = ssl_r;
              end
            end
          end
          rcw_pkg::CMD_DUP: begin
            if (cc_enable) begin
              if (phase_r == rcw_pkg::PH_FR) begin
                cwnd_nxt = sat_inc(cwnd_r);
              end else if (dup_r + 2'd1 == rcw_pkg::DUP_TRIGGER) begin
                rec_tally_nxt = rec_tally_r + 16'd1;
                phase_nxt     = rcw_pkg::PH_FR;
                ssl_nxt       = halved(cwnd_r);
                cwnd_nxt      = recovery_window(halved(cwnd_r));
                dup_nxt       = 2'd0;
                fr_nxt        = 1'b1;
              end else begin
                dup_nxt = dup_r + 2'd1;
              end
            end
          end
          rcw_pkg::CMD_TIMEOUT: begin
            if (cc_enable) begin
              tmo_tally_nxt = tmo_tally_r + 16'd1;
              phase_nxt     = rcw_pkg::PH_SS;
              ssl_nxt       = halved(cwnd_r);
              cwnd_nxt      = WW'(1);
              dup_nxt       = 2'd0;
            end
          end
          rcw_pkg::CMD_RESTART: begin
            cwnd_nxt = clamp_init(init_window);
          end
          default: begin
          end
        endcase
      end
      BK_EMIT: begin
        if (load_out) begin
          state_nxt = BK_IDLE;
        end
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase
  end

  always_comb begin
    case (cmd_r)
      rcw_pkg::CMD_NEW:     kind = rcw_pkg::EK_NEW;
      rcw_pkg::CMD_DUP:     kind = rcw_pkg::EK_DUP;
      rcw_pkg::CMD_TIMEOUT: kind = rcw_pkg::EK_TIMEOUT;
      default:              kind = rcw_pkg::EK_CONTROL;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      phase_r     <= rcw_pkg::PH_SS;
      cwnd_r      <= clamp_init(rcw_pkg::INIT_WINDOW_RESET);
      ssl_r       <= SSL_RESET;
      dup_r       <= 2'd0;
      avoid_r     <= '0;
      tmo_tally_r <= 16'd0;
      rec_tally_r <= 16'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      cwnd_r      <= cwnd_nxt;
      ssl_r       <= ssl_nxt;
      dup_r       <= dup_nxt;
      avoid_r     <= avoid_nxt;
      tmo_tally_r <= tmo_tally_nxt;
      rec_tally_r <= rec_tally_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    remain_r <= remain_nxt;
    fr_r     <= fr_nxt;
    if (pop_valid && pop_ready) begin
      cmd_r   <= pop_data.cmd;
      acked_r <= rcw_pkg::win_field_t'(pop_data.count);
    end
    if (load_out) begin
      out_data_r.event_kind            <= kind;
      out_data_r.acked_count           <= acked_r;
      out_data_r.window_now            <= rcw_pkg::win_field_t'(cwnd_r);
      out_data_r.threshold_now         <= rcw_pkg::win_field_t'(ssl_r);
      out_data_r.phase_now             <= phase_r;
      out_data_r.fast_retransmit       <= fr_r;
      out_data_r.timeouts_total        <= tmo_tally_r;
      out_data_r.fast_recoveries_total <= rec_tally_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
`default_nettype wire

// ===== rtl/reno_congestion_window_top.sv =====
// Top level of the Reno congestion window tracker with configuration registers.
//
//   Channel  Ports                          Word
//   in       in_valid  in_ready  in_data    op, ack_number, expected_base
//   out      out_valid out_ready out_data   event_kind .. fast_recoveries_total
//   cfg      cfg_valid cfg_ready            cfg_index, cfg_data
//
// The front end takes one word per cycle while the two-entry command queue has room.
// With window adjustment on, the window engine applies a new ack that acknowledges n units
// one acked unit per cycle; every event passes through its idle, execute and emit states.
// Reset is synchronous; there is no clearing pass.
// A stalled result waits in the output register while the front end keeps filling the queue.
`default_nettype none
module reno_congestion_window_top #(
  parameter int unsigned MAX_WINDOW = 1024
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire rcw_pkg::in_word_t    in_data,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output rcw_pkg::out_word_t        out_data,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [1:0]           cfg_index,
  input  wire rcw_pkg::win_field_t  cfg_data
);

  logic                cc_enable_r;
  rcw_pkg::win_field_t init_window_r;
  logic                push_valid;
  logic                push_ready;
  rcw_pkg::cmd_word_t  push_data;
  logic                pop_valid;
  logic                pop_ready;
  rcw_pkg::cmd_word_t  pop_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cc_enable_r   <= 1'b0;
      init_window_r <= rcw_pkg::INIT_WINDOW_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        rcw_pkg::CFG_CC_ENABLE:   cc_enable_r   <= cfg_data[0];
        rcw_pkg::CFG_INIT_WINDOW: init_window_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  rcw_front #(
    .MAX_WINDOW(MAX_WINDOW)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .push_data (push_data)
  );

  rcw_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .push_data (push_data),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data)
  );

  rcw_back #(
    .MAX_WINDOW(MAX_WINDOW)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cc_enable  (cc_enable_r),
    .init_window(init_window_r),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

  a_fr_is_dup_entry: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.fast_retransmit |->
      out_data.event_kind == rcw_pkg::EK_DUP && out_data.phase_now == rcw_pkg::PH_FR)
    else $error("fast retransmit flagged outside a duplicate entering recovery");

  a_acked_only_new: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.event_kind != rcw_pkg::EK_NEW |-> out_data.acked_count == '0)
    else $error("acked count nonzero on an event that is not a new ack");

  a_timeout_resets: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && cc_enable_r && out_data.event_kind == rcw_pkg::EK_TIMEOUT |->
      out_data.phase_now == rcw_pkg::PH_SS && out_data.window_now == 11'd1)
    else $error("timeout did not drop the window to one in slow start");

endmodule
`default_nettype wire

// ===== bench/tb.sv =====
// Self-checking testbench for the Reno congestion window tracker top level.
`timescale 1ns / 1ps
module tb;

  localparam int unsigned         MAX_WINDOW   = 1024;
  localparam rcw_pkg::win_field_t MAX_WIN      = 11'd1024;
  localparam logic [1:0]          CFG_UNUSED   = 2'd3;
  localparam int                  HOLD_CYCLES  = 400;
  localparam int                  QUIET_LIMIT  = 8000;
  localparam int                  ERROR_PRINTS = 100;

  typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} gap_mode_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  rcw_pkg::in_word_t   in_data = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  rcw_pkg::out_word_t  out_data;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [1:0]          cfg_index = rcw_pkg::CFG_CC_ENABLE;
  rcw_pkg::win_field_t cfg_data = '0;

  reno_congestion_window_top #(.MAX_WINDOW(MAX_WINDOW)) u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  rcw_pkg::in_word_t  queued_events[$];
  rcw_pkg::out_word_t predicted_reports[$];
  gap_mode_t gap_mode = IDLE_NONE;
  int        hold_token = 0;
  int        hold_seen = 0;
  int        hold_left = 0;
  int        issued_total = 0;
  int        results_seen = 0;
  int        quiet_cycles = 0;
  int        fault_count = 0;
  logic      in_fire = 1'b0;
  logic [31:0] gen_next_ack;

  // Shadow of the congestion state and of the configuration registers.
  logic [1:0]          cc_phase;
  rcw_pkg::win_field_t cc_window;
  rcw_pkg::win_field_t cc_ssthresh;
  rcw_pkg::win_field_t cc_avoid;
  logic [1:0]          cc_dups;
  logic [31:0]         cc_next_ack;
  logic [15:0]         cc_timeouts;
  logic [15:0]         cc_recoveries;
  logic                reg_enable;
  rcw_pkg::win_field_t reg_init_window;
  rcw_pkg::win_field_t reg_init_threshold;

  function automatic rcw_pkg::win_field_t win_inc(rcw_pkg::win_field_t v);
    return (v >= MAX_WIN) ? MAX_WIN : v + 11'd1;
  endfunction

  function automatic rcw_pkg::win_field_t win_clamp(rcw_pkg::win_field_t v);
    if (v == '0) return 11'd1;
    if (v > MAX_WIN) return MAX_WIN;
    return v;
  endfunction

  function automatic rcw_pkg::win_field_t win_half(rcw_pkg::win_field_t v);
    return (v < 11'd2) ? 11'd1 : (v >> 1);
  endfunction

  function automatic void reset_shadow();
    reg_enable = 1'b0;
    reg_init_window = rcw_pkg::INIT_WINDOW_RESET;
    reg_init_threshold = 11'(rcw_pkg::RESET_THRESHOLD);
    cc_phase = rcw_pkg::PH_SS;
    cc_window = win_clamp(reg_init_window);
    cc_ssthresh = win_clamp(reg_init_threshold);
    cc_dups = 2'd0;
    cc_avoid = '0;
    cc_next_ack = rcw_pkg::EXPECTED_RESET;
    cc_timeouts = '0;
    cc_recoveries = '0;
  endfunction

  function automatic void credit_unit();
    case (cc_phase)
      rcw_pkg::PH_SS: begin
        cc_window = win_inc(cc_window);
        cc_dups = 2'd0;
        if (cc_window > cc_ssthresh) begin
          cc_phase = rcw_pkg::PH_CA;
          cc_avoid = '0;
        end
      end
      rcw_pkg::PH_CA: begin
        cc_avoid = win_inc(cc_avoid);
        if (cc_avoid >= cc_window) begin
          cc_avoid = '0;
          cc_window = win_inc(cc_window);
        end
        cc_dups = 2'd0;
      end
      default: begin
        cc_phase = rcw_pkg::PH_CA;
        cc_window = cc_ssthresh;
        cc_dups = 2'd0;
      end
    endcase
  endfunction

  function automatic rcw_pkg::out_word_t reno_react(rcw_pkg::in_word_t w);
    rcw_pkg::out_word_t  r;
    logic [31:0]         span;
    rcw_pkg::win_field_t units;
    r = '0;
    r.event_kind = rcw_pkg::EK_CONTROL;
    case (w.op)
      rcw_pkg::OP_ACK: begin
        if (w.ack_number >= cc_next_ack) begin
          span = w.ack_number - cc_next_ack + 32'd1;
          units = (span > 32'(MAX_WINDOW)) ? MAX_WIN : span[10:0];
          cc_next_ack = w.ack_number + 32'd1;
          r.event_kind = rcw_pkg::EK_NEW;
          r.acked_count = units;
          if (reg_enable) begin
            for (int i = 0; i < int'(units); i++) credit_unit();
          end
        end else begin
          r.event_kind = rcw_pkg::EK_DUP;
          if (reg_enable) begin
            if (cc_phase == rcw_pkg::PH_FR) begin
              cc_window = win_inc(cc_window);
            end else begin
              cc_dups = cc_dups + 2'd1;
              if (cc_dups == rcw_pkg::DUP_TRIGGER) begin
                cc_recoveries = cc_recoveries + 16'd1;
                cc_phase = rcw_pkg::PH_FR;
                cc_ssthresh = win_half(cc_window);
                cc_window = win_clamp(cc_ssthresh + 11'(rcw_pkg::DUP_TRIGGER));
                cc_dups = 2'd0;
                r.fast_retransmit = 1'b1;
              end
            end
          end
        end
      end
      rcw_pkg::OP_TIMEOUT: begin
        r.event_kind = rcw_pkg::EK_TIMEOUT;
        if (reg_enable) begin
          cc_timeouts = cc_timeouts + 16'd1;
          cc_phase = rcw_pkg::PH_SS;
          cc_ssthresh = win_half(cc_window);
          cc_window = 11'd1;
          cc_dups = 2'd0;
        end
      end
      rcw_pkg::OP_LOAD: begin
        cc_next_ack = w.expected_base;
      end
      default: begin
        cc_window = win_clamp(reg_init_window);
      end
    endcase
    r.window_now = cc_window;
    r.threshold_now = cc_ssthresh;
    r.phase_now = cc_phase;
    r.timeouts_total = cc_timeouts;
    r.fast_recoveries_total = cc_recoveries;
    return r;
  endfunction

  function automatic void write_shadow_reg(logic [1:0] idx, rcw_pkg::win_field_t val);
    case (idx)
      rcw_pkg::CFG_CC_ENABLE:      reg_enable = val[0];
      rcw_pkg::CFG_INIT_WINDOW:    reg_init_window = val;
      rcw_pkg::CFG_INIT_THRESHOLD: reg_init_threshold = val;
      default: ;
    endcase
  endfunction

  function automatic bit stall_now(bit mine);
    if (!mine) return 1'b0;
    return $urandom_range(99) < ((gap_mode == IDLE_BOTH) ? 15 : 56);
  endfunction

  task automatic report_field(string fname, int unsigned want, int unsigned got);
    if (want != got) begin
      fault_count++;
      if (fault_count <= ERROR_PRINTS) begin
        $error("%s: expected %0d, got %0d", fname, want, got);
      end
    end
  endtask

  initial begin
    forever #10 clk = ~clk;
  end

  // Sender: presents the next queued word once the current one has been taken.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_fire) begin
      if (queued_events.size() > 0 &&
          !stall_now(gap_mode == IDLE_SENDER || gap_mode == IDLE_BOTH)) begin
        in_data <= queued_events.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls plus a long hold-off on request.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_seen != hold_token) begin
      hold_seen <= hold_token;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else begin
      out_ready <= !stall_now(gap_mode == IDLE_RECEIVER || gap_mode == IDLE_BOTH);
    end
  end

  always @(posedge clk) begin
    rcw_pkg::out_word_t want;
    if (!rst_n) begin
      reset_shadow();
      in_fire <= 1'b0;
      quiet_cycles <= 0;
    end else begin
      in_fire <= in_valid && in_ready;
      if (cfg_valid && cfg_ready) write_shadow_reg(cfg_index, cfg_data);
      if (out_valid && out_ready) begin
        results_seen <= results_seen + 1;
        if (predicted_reports.size() == 0) begin
          fault_count++;
          $error("result word with no prediction pending");
        end else begin
          want = predicted_reports.pop_front();
          report_field("event_kind", want.event_kind, out_data.event_kind);
          report_field("acked_count", want.acked_count, out_data.acked_count);
          report_field("window_now", want.window_now, out_data.window_now);
          report_field("threshold_now", want.threshold_now, out_data.threshold_now);
          report_field("phase_now", want.phase_now, out_data.phase_now);
          report_field("fast_retransmit", want.fast_retransmit, out_data.fast_retransmit);
          report_field("timeouts_total", want.timeouts_total, out_data.timeouts_total);
          report_field("fast_recoveries_total", want.fast_recoveries_total,
                       out_data.fast_recoveries_total);
        end
      end
      if (in_valid && in_ready) predicted_reports.push_back(reno_react(in_data));
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("FAIL reno_congestion_window_top");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic queue_event(logic [1:0] op, logic [31:0] ackn, logic [31:0] base);
    rcw_pkg::in_word_t w;
    w.op = op;
    w.ack_number = ackn;
    w.expected_base = base;
    if (op == rcw_pkg::OP_ACK && ackn >= gen_next_ack) gen_next_ack = ackn + 32'd1;
    if (op == rcw_pkg::OP_LOAD) gen_next_ack = base;
    queued_events.push_back(w);
    issued_total++;
  endtask

  task automatic queue_dup();
    queue_event(rcw_pkg::OP_ACK, gen_next_ack - 32'd1, $urandom);
  endtask

  task automatic add_random_events();
    int unsigned pick;
    int unsigned units;
    logic [31:0] base;
    pick = $urandom_range(99);
    if (pick < 55) begin
      units = $urandom_range(99);
      if (units < 80) units = $urandom_range(1, 4);
      else if (units < 97) units = $urandom_range(5, 40);
      else units = $urandom_range(500, 3000);
      queue_event(rcw_pkg::OP_ACK, gen_next_ack + units - 32'd1, $urandom);
    end else if (pick < 75) begin
      repeat ($urandom_range(1, 5)) begin
        queue_event(rcw_pkg::OP_ACK, gen_next_ack - 32'd1 - $urandom_range(0, 3), $urandom);
      end
    end else if (pick < 80) begin
      queue_event(rcw_pkg::OP_TIMEOUT, $urandom, $urandom);
    end else if (pick < 86) begin
      case ($urandom_range(2))
        0:       base = $urandom;
        1:       base = 32'hFFFF_FFF0 + $urandom_range(15);
        default: base = gen_next_ack + $urandom_range(50);
      endcase
      queue_event(rcw_pkg::OP_LOAD, $urandom, base);
    end else if (pick < 91) begin
      queue_event(rcw_pkg::OP_RESTART, $urandom, $urandom);
    end else begin
      queue_event(2'($urandom_range(3)), $urandom, $urandom);
    end
  endtask

  task automatic write_reg(logic [1:0] idx, rcw_pkg::win_field_t val);
    @(negedge clk);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic settle();
    while (results_seen != issued_total) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic run_phase(logic en, rcw_pkg::win_field_t win, rcw_pkg::win_field_t thr,
                           gap_mode_t mode, bit hold, int count);
    int goal;
    settle();
    write_reg(rcw_pkg::CFG_CC_ENABLE, {10'd0, en});
    write_reg(rcw_pkg::CFG_INIT_WINDOW, win);
    write_reg(rcw_pkg::CFG_INIT_THRESHOLD, thr);
    @(posedge clk);
    gap_mode = mode;
    if (hold) hold_token++;
    goal = issued_total + count;
    while (issued_total < goal) add_random_events();
  endtask

  initial begin
    gen_next_ack = rcw_pkg::EXPECTED_RESET;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Window adjustment off: only classification and the expected ack move.
    queue_event(rcw_pkg::OP_ACK, gen_next_ack, $urandom);
    queue_event(rcw_pkg::OP_ACK, 32'd0, 32'hFFFF_FFFF);
    queue_event(rcw_pkg::OP_TIMEOUT, $urandom, $urandom);
    queue_event(rcw_pkg::OP_RESTART, $urandom, $urandom);
    queue_event(rcw_pkg::OP_ACK, gen_next_ack + 32'd2, $urandom);
    settle();
    write_reg(rcw_pkg::CFG_CC_ENABLE, 11'h7FF);
    write_reg(rcw_pkg::CFG_INIT_THRESHOLD, 11'd0);
    @(posedge clk);

    // An ack of all ones against zero wraps to no units; then slow start,
    // fast recovery entry and exit, a saturated ack and repeated timeouts.
    queue_event(rcw_pkg::OP_LOAD, $urandom, 32'd0);
    queue_event(rcw_pkg::OP_ACK, 32'hFFFF_FFFF, $urandom);
    queue_event(rcw_pkg::OP_ACK, gen_next_ack + 32'd19, $urandom);
    repeat (4) queue_dup();
    queue_event(rcw_pkg::OP_ACK, gen_next_ack, $urandom);
    queue_event(rcw_pkg::OP_ACK, gen_next_ack + 32'd4999, $urandom);
    queue_event(rcw_pkg::OP_TIMEOUT, $urandom, $urandom);
    queue_event(rcw_pkg::OP_TIMEOUT, $urandom, $urandom);
    queue_event(rcw_pkg::OP_RESTART, $urandom, $urandom);
    settle();
    write_reg(rcw_pkg::CFG_INIT_WINDOW, MAX_WIN);
    write_reg(rcw_pkg::CFG_INIT_THRESHOLD, 11'h7FF);
    @(posedge clk);

    // Largest window: growth saturates, then the third duplicate halves it.
    queue_event(rcw_pkg::OP_RESTART, $urandom, $urandom);
    queue_event(rcw_pkg::OP_ACK, gen_next_ack + 32'd1499, $urandom);
    repeat (3) queue_dup();
    settle();
    write_reg(rcw_pkg::CFG_INIT_WINDOW, 11'd0);
    @(posedge clk);
    queue_event(rcw_pkg::OP_RESTART, $urandom, $urandom);
    settle();
    write_reg(rcw_pkg::CFG_INIT_WINDOW, 11'h7FF);
    write_reg(rcw_pkg::CFG_INIT_THRESHOLD, 11'd1);
    write_reg(CFG_UNUSED, 11'($urandom));
    @(posedge clk);
    queue_event(rcw_pkg::OP_RESTART, $urandom, $urandom);

    run_phase(1'b1, 11'd1, 11'd16, IDLE_NONE, 1'b0, 180);
    run_phase(1'b1, MAX_WIN, MAX_WIN, IDLE_SENDER, 1'b0, 180);
    run_phase(1'b1, 11'd0, 11'd0, IDLE_RECEIVER, 1'b1, 180);
    run_phase(1'b0, 11'h7FF, 11'h7FF, IDLE_BOTH, 1'b0, 150);
    run_phase(1'b1, 11'($urandom_range(1, 1024)), 11'($urandom_range(1, 1024)),
              IDLE_BOTH, 1'b0, 200);
    run_phase(1'b1, 11'd37, 11'd8, IDLE_NONE, 1'b0, 210);

    settle();
    repeat (20) @(posedge clk);
    if (predicted_reports.size() != 0) begin
      fault_count++;
      $error("%0d predicted result words never arrived", predicted_reports.size());
    end
    if (fault_count == 0) begin
      $display("PASS reno_congestion_window_top");
    end else begin
      $display("FAIL reno_congestion_window_top");
    end
    $finish;
  end

endmodule
